// File: hdl/aqfp_pkg.sv
package aqfp_pkg;

   localparam logic [7:0] HDR_FIRST  = 8'h2C;
   localparam logic [7:0] HDR_SECOND = 8'hE4;

   localparam int DATA_COUNT = 6;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_SUM  = 2'd1;
   localparam logic [1:0] STATUS_ZERO_CO2 = 2'd2;

   typedef struct packed {
      logic [1:0]  frame_status;
      logic [15:0] tvoc_value;
      logic [15:0] formaldehyde_value;
      logic [15:0] co2_value;
   } result_type;

   typedef struct packed {
      logic       done;
      result_type result;
   } parse_out_type;

endpackage

// File: hdl/aqfp_if.sv
interface aqfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface aqfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  frame_status;
   logic [15:0] tvoc_value;
   logic [15:0] formaldehyde_value;
   logic [15:0] co2_value;

   modport source (output valid, output frame_status, output tvoc_value,
                   output formaldehyde_value, output co2_value, input ready);
   modport sink (input valid, input frame_status, input tvoc_value,
                 input formaldehyde_value, input co2_value, output ready);
endinterface

// File: hdl/aqfp_parse.sv
module aqfp_parse (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   byte_take,
   input  logic [7:0]             rx_byte,
   output aqfp_pkg::parse_out_type parse_out
);
   import aqfp_pkg::*;

   localparam logic [3:0] PHASE_HUNT  = 4'd0;
   localparam logic [3:0] PHASE_HDR   = 4'd1;
   localparam logic [3:0] PHASE_DATA  = 4'd2;
   localparam logic [3:0] PHASE_CHECK = 4'd8;

   logic [3:0]  phase_ff, phase_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  pending_ff [DATA_COUNT];
   logic [15:0] tvoc_ff, tvoc_in;
   logic [15:0] ch2o_ff, ch2o_in;
   logic [15:0] co2_ff, co2_in;
   logic [2:0]  data_index;
   logic        store_data;
   logic [1:0]  status;

   assign data_index = 3'(phase_ff - PHASE_DATA);

   always_comb begin
      phase_in   = phase_ff;
      sum_in     = sum_ff;
      tvoc_in    = tvoc_ff;
      ch2o_in    = ch2o_ff;
      co2_in     = co2_ff;
      store_data = 1'b0;
      status     = STATUS_OK;
      parse_out.done = 1'b0;
      if (phase_ff == PHASE_HDR) begin
         if (rx_byte == HDR_SECOND) begin
            sum_in   = HDR_FIRST + HDR_SECOND;
            phase_in = PHASE_DATA;
         end else begin
            phase_in = PHASE_HUNT;
         end
      end else if (phase_ff >= PHASE_DATA && phase_ff < PHASE_CHECK) begin
         store_data = 1'b1;
         sum_in     = sum_ff + rx_byte;
         phase_in   = phase_ff + 4'd1;
      end else if (phase_ff == PHASE_CHECK) begin
         parse_out.done = 1'b1;
         if (sum_ff != rx_byte) begin
            status = STATUS_BAD_SUM;
         end else if (pending_ff[5] == 8'd0) begin
            status = STATUS_ZERO_CO2;
         end else begin
            tvoc_in = {pending_ff[0], pending_ff[1]};
            ch2o_in = {pending_ff[2], pending_ff[3]};
            co2_in  = {pending_ff[4], pending_ff[5]};
         end
         phase_in = PHASE_HUNT;
         sum_in   = 8'd0;
      end else begin
         phase_in = (rx_byte == HDR_FIRST) ? PHASE_HDR : PHASE_HUNT;
      end
      parse_out.result.frame_status       = status;
      parse_out.result.tvoc_value         = tvoc_in;
      parse_out.result.formaldehyde_value = ch2o_in;
      parse_out.result.co2_value          = co2_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_HUNT;
         sum_ff   <= 8'd0;
         tvoc_ff  <= 16'd0;
         ch2o_ff  <= 16'd0;
         co2_ff   <= 16'd0;
      end else if (byte_take) begin
         phase_ff <= phase_in;
         sum_ff   <= sum_in;
         tvoc_ff  <= tvoc_in;
         ch2o_ff  <= ch2o_in;
         co2_ff   <= co2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (byte_take && store_data) begin
         pending_ff[data_index] <= rx_byte;
      end
   end

endmodule

// File: hdl/air_quality_frame_parser.sv
// Air quality sensor frame parser.
// req_chan carries one received byte per transfer. The block hunts for the
// header 0x2C 0xE4, collects six data bytes (TVOC, CH2O, CO2, high byte
// first) and a checksum byte, the 8-bit sum of header and data bytes.
// rsp_chan carries one result per checksum byte: the frame status and the
// latched readings; readings update only when the checksum matches and the
// CO2 low byte is nonzero. Other bytes produce no result.
// Latency: a result is valid on rsp_chan in the cycle after its checksum
// byte transfers. Throughput: one byte per cycle unless a held result stalls,
// set by the per-byte parser update and one output register.
// A new byte is taken while a result waits, as long as that result leaves
// in the same cycle; when the receiver stalls with a result held, req_chan
// ready drops until the result transfers.
// Reset (synchronous) returns to hunting, clears the checksum and the
// latched readings and empties the output register.
module air_quality_frame_parser (
   input  logic        clock,
   input  logic        reset,
   aqfp_req_if.sink    req_chan,
   aqfp_rsp_if.source  rsp_chan
);
   import aqfp_pkg::*;

   logic          byte_take;
   parse_out_type parse_out;
   logic          rsp_valid_ff, rsp_valid_in;
   result_type    rsp_data_ff;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign byte_take      = req_chan.valid && req_chan.ready;

   aqfp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .byte_take (byte_take),
      .rx_byte   (req_chan.rx_byte),
      .parse_out (parse_out)
   );

   assign rsp_valid_in = byte_take ? parse_out.done : (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (byte_take && parse_out.done) begin
         rsp_data_ff <= parse_out.result;
      end
   end

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.frame_status       = rsp_data_ff.frame_status;
   assign rsp_chan.tvoc_value         = rsp_data_ff.tvoc_value;
   assign rsp_chan.formaldehyde_value = rsp_data_ff.formaldehyde_value;
   assign rsp_chan.co2_value          = rsp_data_ff.co2_value;

endmodule
